// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the core RTL files.
// Included by the top level of the key cache; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/fkc_pkg.sv -----
// Package of the fingerprint key cache: request codes, entry and search
// token types, and the fingerprint masking function. Depends on nothing.
package fkc_pkg;

  localparam int unsigned LEN_W    = 8;
  localparam int unsigned FP_BYTES = 27;
  localparam int unsigned FP_W     = FP_BYTES * 8;
  localparam int unsigned KEY_W    = 256;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned IN_W     = 480;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [FP_W-1:0]  fp;
    logic [KEY_W-1:0] keys;
  } entry_t;

  typedef struct packed {
    logic             lookup;
    logic [LEN_W-1:0] len;
    logic [FP_W-1:0]  fp;
    logic             hit;
    logic [KEY_W-1:0] keys;
  } tok_t;

  typedef struct packed {
    logic we;
    logic clr;
  } cell_wr_t;

  // Zero every fingerprint byte at or past the message length.
  function automatic logic [FP_W-1:0] mask_fp(logic [FP_W-1:0] fp, logic [LEN_W-1:0] len);
    logic [FP_W-1:0] res;
    res = '0;
    for (int i = 0; i < FP_BYTES; i++) begin
      if (int'(len) > i) begin
        res[FP_W-1-8*i -: 8] = fp[FP_W-1-8*i -: 8];
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/fkc_cell.sv -----
// One entry of the key cache and one stage of the search chain.
// Depends on fkc_pkg.
module fkc_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  fkc_pkg::cell_wr_t wr_i,
  input  fkc_pkg::entry_t   wr_data_i,
  input  logic              tok_vld_i,
  input  fkc_pkg::tok_t     tok_i,
  output logic              tok_vld_o,
  output fkc_pkg::tok_t     tok_o
);

  logic            valid_q;
  fkc_pkg::entry_t entry_q;
  logic            tok_vld_q;
  fkc_pkg::tok_t   tok_q, tok_d;
  logic            match;

  always_comb begin
    match = valid_q && tok_i.lookup && !tok_i.hit &&
            (entry_q.len == tok_i.len) && (entry_q.fp == tok_i.fp);
    tok_d = tok_i;
    if (match) begin
      tok_d.hit  = 1'b1;
      tok_d.keys = entry_q.keys;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      if (wr_i.clr) begin
        valid_q <= 1'b0;
      end else if (wr_i.we) begin
        valid_q <= 1'b1;
      end
      if (adv_i) begin
        tok_vld_q <= tok_vld_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      entry_q <= wr_data_i;
    end
    if (adv_i && tok_vld_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

endmodule

// ----- rtl/core/fingerprint_key_cache_core.sv -----
// Top level of the fingerprint key cache: input decode, replace pointer,
// the row of fkc_cell entries and the output register. Depends on fkc_pkg.
// Each request (lookup, store or clear) returns exactly one result. A request
// travels through a chain of CACHE_DEPTH cells, one cell per cycle while the
// chain is not stalled; the result is then loaded into the output register.
// One request is in flight at a time: the next one can be accepted once the
// prior result is loaded. A result that waits in the output register stalls
// the chain and holds off the next request. Stores and clears take effect when
// they are accepted. The first valid entry in index order that matches both
// length and masked fingerprint wins a lookup; misses and non-lookup requests
// return hit low with all keys zero.
`include "assert_macros.svh"

module fingerprint_key_cache_core #(
  parameter int unsigned CACHE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: msg_length, fp_word0, fp_word1, fp_word2, fp_word3,
  // odd_in_hi, odd_in_lo, even_in_hi, even_in_lo.
  input  logic [479:0] s_axis_tdata,
  // Fields from bit 0: req_type.
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0: odd_out_hi, odd_out_lo, even_out_hi, even_out_lo.
  output logic [255:0] m_axis_tdata,
  // Fields from bit 0: hit.
  output logic         m_axis_tuser
);

  localparam int unsigned IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  logic                   s_accept;
  fkc_pkg::req_e          req;
  logic [7:0]             in_len;
  logic [fkc_pkg::FP_W-1:0] in_fp;
  fkc_pkg::entry_t        wr_data;
  fkc_pkg::tok_t          tok_in;
  logic [IDX_W-1:0]       ptr_q, ptr_d;
  logic                   busy_q, busy_d;
  logic                   out_vld_q, out_vld_d;
  logic                   out_hit_q;
  logic [255:0]           out_keys_q;
  logic                   adv, load_out;

  logic                   vld_chain [CACHE_DEPTH+1];
  fkc_pkg::tok_t          tok_chain [CACHE_DEPTH+1];
  logic [CACHE_DEPTH-1:0] vld_vec;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy_q;
  assign req    = fkc_pkg::req_e'(s_axis_tuser);
  assign in_len = s_axis_tdata[7:0];
  assign in_fp  = fkc_pkg::mask_fp({s_axis_tdata[71:8], s_axis_tdata[135:72],
                                    s_axis_tdata[199:136], s_axis_tdata[223:200]}, in_len);

  always_comb begin
    wr_data.len  = in_len;
    wr_data.fp   = in_fp;
    wr_data.keys = s_axis_tdata[479:224];
    tok_in.lookup = (req == fkc_pkg::REQ_LOOKUP);
    tok_in.len    = in_len;
    tok_in.fp     = in_fp;
    tok_in.hit    = 1'b0;
    tok_in.keys   = '0;
  end

  assign vld_chain[0] = s_accept;
  assign tok_chain[0] = tok_in;

  assign load_out = vld_chain[CACHE_DEPTH] && (!out_vld_q || m_axis_tready);
  assign adv      = !vld_chain[CACHE_DEPTH] || load_out;

  for (genvar k = 0; k < CACHE_DEPTH; k++) begin : g_cell
    fkc_pkg::cell_wr_t wr;
    always_comb begin
      wr.clr = s_accept && (req == fkc_pkg::REQ_CLEAR);
      wr.we  = s_accept && (req == fkc_pkg::REQ_STORE) && (ptr_q == IDX_W'(k));
    end
    fkc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .wr_i      (wr),
      .wr_data_i (wr_data),
      .tok_vld_i (vld_chain[k]),
      .tok_i     (tok_chain[k]),
      .tok_vld_o (vld_chain[k+1]),
      .tok_o     (tok_chain[k+1])
    );
    assign vld_vec[k] = vld_chain[k+1];
  end

  always_comb begin
    ptr_d = ptr_q;
    if (s_accept && (req == fkc_pkg::REQ_CLEAR)) begin
      ptr_d = '0;
    end else if (s_accept && (req == fkc_pkg::REQ_STORE)) begin
      if (ptr_q == IDX_W'(CACHE_DEPTH - 1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (s_accept) begin
      busy_d = 1'b1;
    end else if (load_out) begin
      busy_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ptr_q     <= ptr_d;
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_hit_q  <= tok_chain[CACHE_DEPTH].hit;
      out_keys_q <= tok_chain[CACHE_DEPTH].keys;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_keys_q;
  assign m_axis_tuser  = out_hit_q;

  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_accept, !s_axis_tready)
  `ASSERT_SAME(a_single_token, clk_i, rst_ni, 1'b1, $onehot0(vld_vec))
  `ASSERT_SAME(a_busy_tracks_chain, clk_i, rst_ni, 1'b1, busy_q == (|vld_vec))
  `ASSERT_SAME(a_ptr_range, clk_i, rst_ni, 1'b1, ptr_q <= IDX_W'(CACHE_DEPTH - 1))

endmodule
